// File: hw/rtl/nnr_pkg.sv
// types and constants shared by the nearest-neighbor resize unit and its checker
package nnr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_WIDTH     = 2'd0,
        CFG_SRC_HEIGHT    = 2'd1,
        CFG_SCALE_FACTOR  = 2'd2,
        CFG_INVERSE_RATIO = 2'd3
    } cfg_index_t;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [6:0]  SRC_WIDTH_RESET     = 7'd64;
    localparam logic [6:0]  SRC_HEIGHT_RESET    = 7'd64;
    localparam logic [9:0]  SCALE_FACTOR_RESET  = 10'd256;
    localparam logic [23:0] INVERSE_RATIO_RESET = 24'd65536;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] out_column;
        logic [7:0] out_line;
        logic       last_pixel;
    } out_item_t;

endpackage

// File: hw/rtl/nearest_neighbor_resize_unit.sv
// nearest-neighbor image scaler: frame store load path and scaled pixel read path
//
//  channel   direction  handshake                payload
//  command   in         start & !busy            req (nnr_pkg::in_item_t)
//  result    out        done strobe, one cycle   result (nnr_pkg::out_item_t)
//  config    in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// one item is taken every cycle; busy stays low
// a pixel result shows on done in the cycle after its item; its colour comes from the registered frame store read port
// reset clears the counters and the frame-full flag; the frame store is not cleared
// the receiver cannot stall, so each result is on the ports for exactly one cycle
module nearest_neighbor_resize_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  nnr_pkg::in_item_t                   req,
    output logic                                done,
    output nnr_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nnr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int CMPW  = LCW > 14 ? LCW : 14;
    localparam int AW2   = AW > 14 ? AW : 14;
    localparam int W_LIM = MAX_WIDTH > 127 ? 127 : MAX_WIDTH;
    localparam int H_LIM = MAX_HEIGHT > 127 ? 127 : MAX_HEIGHT;

    logic [6:0]     src_width_reg;
    logic [6:0]     src_height_reg;
    logic [9:0]     scale_factor_reg;
    logic [23:0]    inverse_ratio_reg;

    logic [LCW-1:0] load_cnt_reg, load_cnt_next;
    logic           frame_full_reg, frame_full_next;
    logic [7:0]     col_cnt_reg, col_cnt_next;
    logic [7:0]     line_cnt_reg, line_cnt_next;
    logic [23:0]    col_pos_reg, col_pos_next;
    logic [23:0]    line_pos_reg, line_pos_next;
    logic           done_reg, done_next;
    logic [7:0]     out_col_reg, out_col_next;
    logic [7:0]     out_line_reg, out_line_next;
    logic           last_reg, last_next;

    logic [6:0]     w_eff, h_eff, w_m1, h_m1, x_idx, y_idx;
    logic [13:0]    frame_size;
    logic [16:0]    ow_prod, oh_prod;
    logic [7:0]     ow, oh;
    logic           accept, in_range, row_end, last_hit;
    logic [AW2-1:0] addr_full;
    logic [LCW-1:0] load_cnt_inc;
    logic           ram_we, ram_re;
    logic [23:0]    ram_rdata;

    function automatic logic [23:0] advance(input logic [23:0] pos, input logic [23:0] step);
        logic [24:0] sum;
        begin
            sum = {1'b0, pos} + {1'b0, step};
            advance = sum[24] ? 24'hFF_FFFF : sum[23:0];
        end
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= nnr_pkg::SRC_WIDTH_RESET;
            src_height_reg    <= nnr_pkg::SRC_HEIGHT_RESET;
            scale_factor_reg  <= nnr_pkg::SCALE_FACTOR_RESET;
            inverse_ratio_reg <= nnr_pkg::INVERSE_RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (nnr_pkg::cfg_index_t'(cfg_index))
                nnr_pkg::CFG_SRC_WIDTH:     src_width_reg     <= cfg_data[6:0];
                nnr_pkg::CFG_SRC_HEIGHT:    src_height_reg    <= cfg_data[6:0];
                nnr_pkg::CFG_SCALE_FACTOR:  scale_factor_reg  <= cfg_data[9:0];
                nnr_pkg::CFG_INVERSE_RATIO: inverse_ratio_reg <= cfg_data[23:0];
                default:                    ;
            endcase
        end
    end

    // effective source size and scaled size
    always_comb
    begin
        w_eff = (src_width_reg == 7'd0) ? 7'd1 :
                (src_width_reg > 7'(W_LIM)) ? 7'(W_LIM) : src_width_reg;
        h_eff = (src_height_reg == 7'd0) ? 7'd1 :
                (src_height_reg > 7'(H_LIM)) ? 7'(H_LIM) : src_height_reg;
        w_m1 = w_eff - 7'd1;
        h_m1 = h_eff - 7'd1;
        frame_size = {7'd0, w_eff} * {7'd0, h_eff};
        ow_prod = {10'd0, w_eff} * {7'd0, scale_factor_reg};
        oh_prod = {10'd0, h_eff} * {7'd0, scale_factor_reg};
        ow = ow_prod[16] ? 8'hFF : ow_prod[15:8];
        oh = oh_prod[16] ? 8'hFF : oh_prod[15:8];
    end

    // source pixel address, clamped to the image edge
    always_comb
    begin
        x_idx = (col_pos_reg[23:16] > {1'b0, w_m1}) ? w_m1 : col_pos_reg[22:16];
        y_idx = (line_pos_reg[23:16] > {1'b0, h_m1}) ? h_m1 : line_pos_reg[22:16];
        addr_full = AW2'(y_idx) * AW2'(w_eff) + AW2'(x_idx);
    end

    always_comb
    begin
        accept   = start && !busy;
        in_range = (col_cnt_reg < ow) && (line_cnt_reg < oh);
        row_end  = col_cnt_reg == (ow - 8'd1);
        last_hit = row_end && (line_cnt_reg == (oh - 8'd1));
        load_cnt_inc = load_cnt_reg + LCW'(1);

        load_cnt_next   = load_cnt_reg;
        frame_full_next = frame_full_reg;
        col_cnt_next    = col_cnt_reg;
        line_cnt_next   = line_cnt_reg;
        col_pos_next    = col_pos_reg;
        line_pos_next   = line_pos_reg;
        done_next       = 1'b0;
        out_col_next    = out_col_reg;
        out_line_next   = out_line_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        if (accept && (req.req_type == nnr_pkg::REQ_LOAD) && !frame_full_reg)
        begin
            if ((CMPW'(load_cnt_reg) < CMPW'(frame_size)) &&
                (CMPW'(load_cnt_reg) < CMPW'(DEPTH)))
            begin
                ram_we        = 1'b1;
                load_cnt_next = load_cnt_inc;
            end
            frame_full_next = CMPW'(load_cnt_next) >= CMPW'(frame_size);
        end
        else if (accept && (req.req_type == nnr_pkg::REQ_PIXEL) && frame_full_reg)
        begin
            if (!in_range || last_hit)
            begin
                // frame released: a new one may load
                load_cnt_next   = '0;
                frame_full_next = 1'b0;
                col_cnt_next    = 8'd0;
                line_cnt_next   = 8'd0;
                col_pos_next    = 24'd0;
                line_pos_next   = 24'd0;
            end
            else if (row_end)
            begin
                col_cnt_next  = 8'd0;
                col_pos_next  = 24'd0;
                line_cnt_next = line_cnt_reg + 8'd1;
                line_pos_next = advance(line_pos_reg, inverse_ratio_reg);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 8'd1;
                col_pos_next = advance(col_pos_reg, inverse_ratio_reg);
            end
            if (in_range)
            begin
                ram_re        = 1'b1;
                done_next     = 1'b1;
                out_col_next  = col_cnt_reg;
                out_line_next = line_cnt_reg;
                last_next     = last_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg   <= '0;
            frame_full_reg <= 1'b0;
            col_cnt_reg    <= 8'd0;
            line_cnt_reg   <= 8'd0;
            col_pos_reg    <= 24'd0;
            line_pos_reg   <= 24'd0;
            done_reg       <= 1'b0;
        end
        else
        begin
            load_cnt_reg   <= load_cnt_next;
            frame_full_reg <= frame_full_next;
            col_cnt_reg    <= col_cnt_next;
            line_cnt_reg   <= line_cnt_next;
            col_pos_reg    <= col_pos_next;
            line_pos_reg   <= line_pos_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_col_reg  <= out_col_next;
        out_line_reg <= out_line_next;
        last_reg     <= last_next;
    end

    nnr_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata ({req.red_in, req.green_in, req.blue_in}),
        .re    (ram_re),
        .raddr (addr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign done              = done_reg;
    assign result.red_out    = ram_rdata[23:16];
    assign result.green_out  = ram_rdata[15:8];
    assign result.blue_out   = ram_rdata[7:0];
    assign result.out_column = out_col_reg;
    assign result.out_line   = out_line_reg;
    assign result.last_pixel = last_reg;

endmodule

// File: hw/rtl/nnr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module nnr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/nnr_checker.sv
// port-level checker for the nearest-neighbor resize unit, with its bind
module nnr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input nnr_pkg::in_item_t                req,
    input logic                             done,
    input nnr_pkg::out_item_t               result
);

    // a result only follows an accepted item in the previous cycle
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted item one cycle earlier");

    // only pixel requests produce results
    a_done_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req.req_type == nnr_pkg::REQ_PIXEL))
        else $error("result caused by a load item");

    // the last pixel releases the frame, so no result can follow right away
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last_pixel) |=> !done)
        else $error("result right after the last pixel of the frame");

    // within a row the column steps by one between back-to-back results
    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && !$past(result.last_pixel) && (result.out_column != 8'd0))
        |-> (result.out_column == $past(result.out_column) + 8'd1))
        else $error("column did not advance by one between results");

endmodule

bind nearest_neighbor_resize_unit nnr_checker u_nnr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result)
);
